>>> hw/rtl/wls_pkg.sv
// shared types, constants and codes for the windowed latency statistics block
package wls_pkg;

  localparam int NUM_SCOPES_DEF    = 9;
  localparam int WINDOW_FRAMES_DEF = 1024;
  localparam int TOP_CAPACITY_DEF  = 11;
  localparam int LOW_DIVISOR_DEF   = 100;

  localparam logic [1:0] FUNC_RECORD    = 2'd0;
  localparam logic [1:0] FUNC_END_FRAME = 2'd1;
  localparam logic [1:0] FUNC_QUERY     = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  scope;
    logic [31:0] elapsed_us;
    logic [31:0] frame_us;
    logic        whole_frame;
  } cmd_t;

  typedef struct packed {
    logic [31:0] average_us;
    logic [31:0] max_us;
    logic [31:0] worst_percent_us;
    logic [31:0] average_entries;
  } stats_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture command
    logic record;      // add to accumulator
    logic ef_clear;    // start end-frame sweep
    logic ef_step;     // store one scope, clear it
    logic ef_finish;   // store frame time, advance ring
    logic q_init;      // clear query sums
    logic q_read;      // issue ring read
    logic q_acc;       // fold read data
    logic top_step;    // add one top value
    logic div_start;   // start divider
    logic div_step;    // one quotient bit
    logic div_next;    // move to next division
    logic zero_out;    // result all zeros
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       scope_ok;
    logic       have_frames;
    logic       ef_last;
    logic       q_last;
    logic       top_last;
    logic       div_done;
    logic       div_all;
    logic       ins_busy;
  } sts_t;

endpackage

>>> hw/rtl/wls_datapath.sv
// datapath: accumulators, frame rings, top-k list and a shared bit-serial divider
module wls_datapath #(
  parameter int NUM_SCOPES    = wls_pkg::NUM_SCOPES_DEF,
  parameter int WINDOW_FRAMES = wls_pkg::WINDOW_FRAMES_DEF,
  parameter int TOP_CAPACITY  = wls_pkg::TOP_CAPACITY_DEF,
  parameter int LOW_DIVISOR   = wls_pkg::LOW_DIVISOR_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  wls_pkg::cmd_t  cmd,
  input  wls_pkg::ctl_t  ctl,
  output wls_pkg::sts_t  sts,
  output wls_pkg::stats_t res
);

  localparam int SW = (NUM_SCOPES > 1) ? $clog2(NUM_SCOPES) : 1;
  localparam int FW = $clog2(WINDOW_FRAMES);
  localparam int CW = FW + 1;
  localparam int AW = SW + FW;
  localparam int KW = $clog2(TOP_CAPACITY + 1);
  localparam int MW = (TOP_CAPACITY > 1) ? $clog2(TOP_CAPACITY) : 1;
  localparam int SUMW = 32 + CW;
  localparam int DEPTH = NUM_SCOPES * WINDOW_FRAMES;

  wls_pkg::cmd_t c;

  logic [63:0] tacc [NUM_SCOPES];
  logic [31:0] eacc [NUM_SCOPES];
  logic [31:0] tmem [DEPTH];
  logic [31:0] emem [DEPTH];
  logic [31:0] fmem [WINDOW_FRAMES];

  logic [FW-1:0] wslot;
  logic [CW-1:0] frames;
  logic [SW-1:0] ef_idx;
  logic [CW-1:0] qi;
  logic          rd_v;
  logic [31:0]   tq, eq, fq;

  logic [SUMW-1:0] sum, sum_ent, sum_top;
  logic [31:0]     maxv;
  logic [31:0]     best [TOP_CAPACITY];
  logic [KW-1:0]   held, kval, ti;
  logic [31:0]     samp;

  // insertion engine: shifts one slot a cycle
  logic          ins_act;
  logic [31:0]   ins_v;
  logic [MW-1:0] ins_i;
  logic          ins_grow;

  // divider
  logic [1:0]      dsel;
  logic [SUMW-1:0] dnum, dquo;
  logic [SUMW:0]   drem;
  logic [CW-1:0]   dden;
  logic [$clog2(SUMW+1)-1:0] dcnt;
  logic [SUMW:0]   drem_sh;

  logic [KW-1:0] kcalc;
  logic          scope_in;

  function automatic logic [AW-1:0] addr(input logic [3:0] s, input logic [FW-1:0] f);
    logic [AW+3:0] a;
    a = (AW+4)'(s) * (AW+4)'(WINDOW_FRAMES) + (AW+4)'(f);
    return a[AW-1:0];
  endfunction

  // top-k size: frames / LOW_DIVISOR clamped to 1..TOP_CAPACITY, by threshold compares
  always_comb begin
    kcalc = KW'(1);
    for (int j = 2; j <= TOP_CAPACITY; j++)
      if (32'(frames) >= 32'(j * LOW_DIVISOR)) kcalc = KW'(j);
  end

  assign samp = c.whole_frame ? fq : tq;
  assign drem_sh = {drem[SUMW-1:0], dnum[SUMW-1 - dcnt]};
  assign scope_in = 32'(c.scope) < NUM_SCOPES;

  assign sts.func        = c.func;
  assign sts.scope_ok    = c.whole_frame || scope_in;
  assign sts.have_frames = frames != '0;
  assign sts.ef_last     = 32'(ef_idx) == NUM_SCOPES - 1;
  assign sts.q_last      = qi == frames;
  assign sts.top_last    = ti == held - KW'(1);
  assign sts.div_done    = 32'(dcnt) == SUMW - 1;
  assign sts.div_all     = dsel == 2'd2;
  assign sts.ins_busy    = ins_act;

  always_ff @(posedge clk) begin
    if (ctl.load) c <= cmd;
    if (ctl.record && scope_in) begin
      tacc[c.scope[SW-1:0]] <= tacc[c.scope[SW-1:0]] + 64'(c.elapsed_us);
      eacc[c.scope[SW-1:0]] <= eacc[c.scope[SW-1:0]] + 32'd1;
    end
    if (ctl.ef_step) begin
      tmem[addr(4'(ef_idx), wslot)] <= (tacc[ef_idx][63:32] != '0) ? '1 : tacc[ef_idx][31:0];
      emem[addr(4'(ef_idx), wslot)] <= eacc[ef_idx];
      tacc[ef_idx] <= '0;
      eacc[ef_idx] <= '0;
    end
    if (ctl.ef_finish) fmem[wslot] <= c.frame_us;
    tq <= tmem[addr(c.scope, qi[FW-1:0])];
    eq <= emem[addr(c.scope, qi[FW-1:0])];
    fq <= fmem[qi[FW-1:0]];
    rd_v <= ctl.q_read;

    if (ctl.q_init) begin
      sum <= '0; sum_ent <= '0; sum_top <= '0; maxv <= '0; held <= '0; ti <= '0;
      kval <= kcalc;
    end
    if (ctl.q_acc && rd_v) begin
      sum <= sum + SUMW'(samp);
      if (!c.whole_frame) sum_ent <= sum_ent + SUMW'(eq);
      if (samp > maxv) maxv <= samp;
      if (held < kval) begin
        ins_act <= 1'b1; ins_v <= samp; ins_grow <= 1'b1; ins_i <= MW'(held);
        held <= held + KW'(1);
      end else if (samp > best[0]) begin
        ins_act <= 1'b1; ins_v <= samp; ins_grow <= 1'b0; ins_i <= '0;
      end
    end else if (ins_act) begin
      if (ins_grow) begin
        if (ins_i != '0 && best[ins_i - MW'(1)] > ins_v) begin
          best[ins_i] <= best[ins_i - MW'(1)];
          ins_i <= ins_i - MW'(1);
        end else begin
          best[ins_i] <= ins_v; ins_act <= 1'b0;
        end
      end else begin
        if (KW'(ins_i) + KW'(1) < kval && best[ins_i + MW'(1)] < ins_v) begin
          best[ins_i] <= best[ins_i + MW'(1)];
          ins_i <= ins_i + MW'(1);
        end else begin
          best[ins_i] <= ins_v; ins_act <= 1'b0;
        end
      end
    end
    if (ctl.top_step) begin
      sum_top <= sum_top + SUMW'(best[ti[MW-1:0]]);
      ti <= ti + KW'(1);
    end

    if (ctl.div_start) begin
      dsel <= '0; dnum <= sum; dden <= frames; drem <= '0; dcnt <= '0;
    end
    if (ctl.div_step) begin
      if (drem_sh >= (SUMW+1)'(dden)) begin
        drem <= drem_sh - (SUMW+1)'(dden);
        dquo[SUMW-1 - dcnt] <= 1'b1;
      end else begin
        drem <= drem_sh;
        dquo[SUMW-1 - dcnt] <= 1'b0;
      end
      dcnt <= dcnt + 1'b1;
    end
    if (ctl.div_next) begin
      drem <= '0; dcnt <= '0; dsel <= dsel + 2'd1;
      unique case (dsel)
        2'd0: begin res.average_us <= dquo[31:0]; dnum <= sum_top; dden <= CW'(held); end
        2'd1: begin res.worst_percent_us <= dquo[31:0]; dnum <= sum_ent; dden <= frames; end
        default: res.average_entries <= dquo[31:0];
      endcase
      if (dsel == 2'd0) res.max_us <= maxv;
    end
    if (ctl.zero_out) res <= '0;

    if (rst) begin
      for (int i = 0; i < NUM_SCOPES; i++) begin
        tacc[i] <= '0; eacc[i] <= '0;
      end
      wslot <= '0; frames <= '0; ins_act <= 1'b0; rd_v <= 1'b0;
    end else if (ctl.ef_finish) begin
      wslot <= (32'(wslot) == WINDOW_FRAMES - 1) ? '0 : wslot + FW'(1);
      if (frames != CW'(WINDOW_FRAMES)) frames <= frames + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ef_clear || ctl.ef_finish) ef_idx <= '0;
    else if (ctl.ef_step) ef_idx <= ef_idx + SW'(1);
    if (ctl.q_init) qi <= '0;
    else if (ctl.q_read) qi <= qi + CW'(1);
  end

endmodule

>>> hw/rtl/wls_controller.sv
// controller state machine sequencing records, end-frame sweeps and queries
module wls_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  input  wls_pkg::sts_t sts,
  output wls_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    IDLE, DECODE, EF_SWEEP, EF_FIN, Q_READ, Q_DRAIN, Q_TOP, Q_DIV, Q_NEXT, FINISH
  } state_t;

  state_t state;
  logic [1:0] drain;

  assign busy = state != IDLE;

  always_comb begin
    ctl = '0;
    ctl.load      = (state == IDLE) && start;
    ctl.record    = (state == DECODE) && (sts.func == wls_pkg::FUNC_RECORD) && sts.scope_ok;
    ctl.ef_clear  = (state == DECODE);
    ctl.q_init    = (state == DECODE);
    ctl.ef_step   = (state == EF_SWEEP);
    ctl.ef_finish = (state == EF_FIN);
    ctl.q_read    = (state == Q_READ) && !sts.ins_busy && !sts.q_last;
    ctl.q_acc     = (state == Q_READ) || (state == Q_DRAIN);
    ctl.top_step  = (state == Q_TOP);
    ctl.div_start = (state == Q_TOP) && sts.top_last;
    ctl.div_step  = (state == Q_DIV);
    ctl.div_next  = (state == Q_NEXT);
    ctl.zero_out  = (state == DECODE) && (sts.func == wls_pkg::FUNC_QUERY)
                    && !(sts.scope_ok && sts.have_frames);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= IDLE;
      drain <= '0;
    end else begin
      unique case (state)
        IDLE: if (start) state <= DECODE;
        DECODE: begin
          priority case (sts.func)
            wls_pkg::FUNC_END_FRAME: state <= EF_SWEEP;
            wls_pkg::FUNC_QUERY:
              state <= (sts.scope_ok && sts.have_frames) ? Q_READ : FINISH;
            default: state <= IDLE;
          endcase
        end
        EF_SWEEP: if (sts.ef_last) state <= EF_FIN;
        EF_FIN: state <= IDLE;
        // one read outstanding at a time so the insertion engine keeps up
        Q_READ: if (!sts.ins_busy) begin
          if (sts.q_last) state <= Q_TOP;
          else begin
            state <= Q_DRAIN;
            drain <= '0;
          end
        end
        Q_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'd1) state <= Q_READ;
        end
        Q_TOP: if (sts.top_last) state <= Q_DIV;
        Q_DIV: if (sts.div_done) state <= Q_NEXT;
        Q_NEXT: state <= sts.div_all ? FINISH : Q_DIV;
        FINISH: begin
          done <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // a record never leaves the idle-decode pair
  assert property (@(posedge clk) disable iff (rst)
    (state == DECODE && sts.func == wls_pkg::FUNC_RECORD) |=> state == IDLE)
    else $error("record did not return to idle");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == FINISH)
    else $error("result strobe outside finish");
  assert property (@(posedge clk) disable iff (rst) (state == Q_TOP) |-> !sts.ins_busy)
    else $error("top sum started while insertion running");

endmodule

>>> hw/rtl/windowed_latency_statistics.sv
// top level of the windowed latency statistics monitor
// A record transaction passes through the decode state only; an end-frame
// transaction steps once per scope, writing each into the frame ring, then
// stores the frame time and advances the ring. A query reads the ring one
// recorded frame at a time, each read folded into a sorted top-k list by a
// one-slot-per-cycle insertion engine, then sums the top list and runs three
// bit-serial divisions. Results appear for one cycle with done high and cannot
// be stalled; busy is low when a new transaction may start. Ring storage is
// not cleared after reset.
module windowed_latency_statistics #(
  parameter int NUM_SCOPES    = wls_pkg::NUM_SCOPES_DEF,
  parameter int WINDOW_FRAMES = wls_pkg::WINDOW_FRAMES_DEF,
  parameter int TOP_CAPACITY  = wls_pkg::TOP_CAPACITY_DEF,
  parameter int LOW_DIVISOR   = wls_pkg::LOW_DIVISOR_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  wls_pkg::cmd_t   cmd,
  output logic            done,
  output wls_pkg::stats_t result
);

  wls_pkg::ctl_t ctl;
  wls_pkg::sts_t sts;

  wls_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .sts(sts), .ctl(ctl)
  );

  wls_datapath #(
    .NUM_SCOPES(NUM_SCOPES), .WINDOW_FRAMES(WINDOW_FRAMES),
    .TOP_CAPACITY(TOP_CAPACITY), .LOW_DIVISOR(LOW_DIVISOR)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .ctl(ctl), .sts(sts), .res(result)
  );

endmodule

>>> dv/tb_windowed_latency_statistics.sv
// testbench for the windowed latency statistics monitor: directed, random and ring-wrap tests
module tb_windowed_latency_statistics;

  localparam int NS        = wls_pkg::NUM_SCOPES_DEF;
  localparam int WIN       = wls_pkg::WINDOW_FRAMES_DEF;
  localparam int TOPK      = wls_pkg::TOP_CAPACITY_DEF;
  localparam int DIVISOR   = wls_pkg::LOW_DIVISOR_DEF;
  localparam int SETTLE    = 24;
  localparam int STALL_MAX = 300000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  wls_pkg::cmd_t   cmd = '0;
  logic            busy;
  logic            done;
  wls_pkg::stats_t result;

  // predictor state
  logic [63:0] time_acc [NS];
  logic [31:0] entry_acc [NS];
  logic [31:0] scope_time_hist [NS][WIN];
  logic [31:0] scope_entry_hist [NS][WIN];
  logic [31:0] frame_time_hist [WIN];
  int unsigned next_slot;
  int unsigned frame_count;

  wls_pkg::stats_t pending_stats [$];
  int     error_count = 0;
  int     idle_pct = 0;
  int     quiet_cycles = 0;

  windowed_latency_statistics dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic wls_pkg::stats_t window_stats(logic whole, logic [3:0] sc);
    wls_pkg::stats_t s;
    logic [31:0] samples [$];
    logic [63:0] sum_t, sum_e, sum_top;
    int unsigned k;
    s = '0;
    sum_t = 0;
    sum_e = 0;
    sum_top = 0;
    if ((!whole && sc >= NS) || frame_count == 0) return s;
    for (int i = 0; i < frame_count; i++) begin
      if (whole) begin
        samples.push_back(frame_time_hist[i]);
        sum_t += frame_time_hist[i];
      end else begin
        samples.push_back(scope_time_hist[sc][i]);
        sum_t += scope_time_hist[sc][i];
        sum_e += scope_entry_hist[sc][i];
      end
    end
    samples.rsort();
    k = frame_count / DIVISOR;
    if (k < 1) k = 1;
    if (k > TOPK) k = TOPK;
    for (int i = 0; i < k; i++) sum_top += samples[i];
    s.average_us       = 32'(sum_t / frame_count);
    s.max_us           = samples[0];
    s.worst_percent_us = 32'(sum_top / k);
    s.average_entries  = 32'(sum_e / frame_count);
    return s;
  endfunction

  task automatic apply_transaction(wls_pkg::cmd_t c);
    case (c.func)
      wls_pkg::FUNC_RECORD: begin
        if (c.scope < NS) begin
          time_acc[c.scope]  += c.elapsed_us;
          entry_acc[c.scope] += 1;
        end
      end
      wls_pkg::FUNC_END_FRAME: begin
        frame_time_hist[next_slot] = c.frame_us;
        for (int s = 0; s < NS; s++) begin
          scope_time_hist[s][next_slot] = (time_acc[s] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                        : time_acc[s][31:0];
          scope_entry_hist[s][next_slot] = entry_acc[s];
          time_acc[s]  = '0;
          entry_acc[s] = '0;
        end
        next_slot = (next_slot + 1) % WIN;
        if (frame_count < WIN) frame_count++;
      end
      wls_pkg::FUNC_QUERY: pending_stats.push_back(window_stats(c.whole_frame, c.scope));
      default: ;
    endcase
  endtask

  // start is left high after acceptance so back-to-back transactions need no extra edge
  task automatic send_cmd(wls_pkg::cmd_t c);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    apply_transaction(c);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic wls_pkg::cmd_t make_cmd(logic [1:0] f, logic [3:0] sc, logic [31:0] el,
                                             logic [31:0] fr, logic wh);
    wls_pkg::cmd_t c;
    c.func = f;
    c.scope = sc;
    c.elapsed_us = el;
    c.frame_us = fr;
    c.whole_frame = wh;
    return c;
  endfunction

  function automatic wls_pkg::cmd_t random_cmd(int rec_pct, int end_pct, int query_pct);
    wls_pkg::cmd_t c;
    int   r;
    r = $urandom_range(99);
    c.func = (r < rec_pct) ? wls_pkg::FUNC_RECORD :
             (r < rec_pct + end_pct) ? wls_pkg::FUNC_END_FRAME :
             (r < rec_pct + end_pct + query_pct) ? wls_pkg::FUNC_QUERY : FUNC_UNUSED;
    c.scope = ($urandom_range(9) == 0) ? 4'($urandom_range(15, NS)) : 4'($urandom_range(NS - 1));
    c.elapsed_us = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(5000));
    c.frame_us = ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(20000));
    c.whole_frame = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic test_directed_edges();
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'd0, '0, '0, 1'b0));          // no frame yet
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'd0, '0, '0, 1'b1));
    send_cmd(make_cmd(wls_pkg::FUNC_RECORD, 4'd0, 32'hFFFF_FFFF, '0, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_RECORD, 4'd0, 32'hFFFF_FFFF, '0, 1'b1)); // saturates
    send_cmd(make_cmd(wls_pkg::FUNC_RECORD, 4'(NS - 1), 32'd0, 32'hFFFF_FFFF, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_RECORD, 4'(NS - 1), 32'h8000_0001, '0, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_RECORD, 4'(NS), 32'd1234, '0, 1'b0));  // bad scope, ignored
    send_cmd(make_cmd(wls_pkg::FUNC_RECORD, 4'd15, 32'hFFFF_FFFF, '0, 1'b1));
    send_cmd(make_cmd(FUNC_UNUSED, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_cmd(make_cmd(wls_pkg::FUNC_END_FRAME, 4'd15, '0, 32'hFFFF_FFFF, 1'b1));
    send_cmd(make_cmd(wls_pkg::FUNC_RECORD, 4'd4, 32'd77, '0, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_END_FRAME, 4'd0, '0, 32'd0, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'd0, '0, '0, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'(NS - 1), '0, '0, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'd4, '0, '0, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'd0, '0, '0, 1'b1));
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'(NS), '0, '0, 1'b0));        // bad scope, zeros
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'd15, '0, '0, 1'b1));
    wait_drained();
  endtask

  task automatic test_random_mix(int pct, int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_cmd(random_cmd(20, 75, 5));
    wait_drained();
  endtask

  // fill the window past its depth so the ring wraps, then query the full window
  task automatic test_window_wrap();
    int extra;
    idle_pct = 10;
    extra = 0;
    while (extra < 40) begin
      send_cmd(random_cmd(3, 97, 0));
      if (frame_count == WIN && cmd.func == wls_pkg::FUNC_END_FRAME) extra++;
    end
    for (int i = 0; i < 6; i++) send_cmd(random_cmd(0, 0, 100));
    send_cmd(make_cmd(wls_pkg::FUNC_QUERY, 4'(NS), '0, '0, 1'b1));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_stats.size() == 0) begin
        $display("unexpected result at %0t", $time);
        error_count++;
      end else begin
        wls_pkg::stats_t want;
        want = pending_stats.pop_front();
        if (result.average_us !== want.average_us)
          report_mismatch("average_us", result.average_us, want.average_us);
        if (result.max_us !== want.max_us)
          report_mismatch("max_us", result.max_us, want.max_us);
        if (result.worst_percent_us !== want.worst_percent_us)
          report_mismatch("worst_percent_us", result.worst_percent_us, want.worst_percent_us);
        if (result.average_entries !== want.average_entries)
          report_mismatch("average_entries", result.average_entries, want.average_entries);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("windowed_latency_statistics test failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NS; s++) begin
      time_acc[s]  = '0;
      entry_acc[s] = '0;
    end
    next_slot = 0;
    frame_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_random_mix(18, 100);
    test_random_mix(45, 100);
    test_random_mix(0, 100);
    test_window_wrap();
    if (pending_stats.size() != 0) begin
      $display("%0d results never arrived", pending_stats.size());
      error_count++;
    end
    if (error_count == 0) $display("windowed_latency_statistics test passed");
    else $display("windowed_latency_statistics test failed");
    $finish;
  end

endmodule
